FILE: rtl/pes_pkg.sv
// pes_pkg: encodings, status codes and the flag bundle of the execute stage
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package pes_pkg;

    // instruction codes
    localparam logic [3:0] IC_RRMOVQ = 4'd2;
    localparam logic [3:0] IC_IRMOVQ = 4'd3;
    localparam logic [3:0] IC_RMMOVQ = 4'd4;
    localparam logic [3:0] IC_MRMOVQ = 4'd5;
    localparam logic [3:0] IC_OPQ    = 4'd6;
    localparam logic [3:0] IC_JXX    = 4'd7;
    localparam logic [3:0] IC_CALL   = 4'd8;
    localparam logic [3:0] IC_RET    = 4'd9;
    localparam logic [3:0] IC_PUSHQ  = 4'd10;
    localparam logic [3:0] IC_POPQ   = 4'd11;

    // alu functions
    localparam logic [3:0] FN_ADD = 4'd0;
    localparam logic [3:0] FN_SUB = 4'd1;
    localparam logic [3:0] FN_AND = 4'd2;
    localparam logic [3:0] FN_XOR = 4'd3;

    // branch / move conditions
    localparam logic [3:0] C_ALWAYS = 4'd0;
    localparam logic [3:0] C_LE     = 4'd1;
    localparam logic [3:0] C_L      = 4'd2;
    localparam logic [3:0] C_E      = 4'd3;
    localparam logic [3:0] C_NE     = 4'd4;
    localparam logic [3:0] C_GE     = 4'd5;
    localparam logic [3:0] C_G      = 4'd6;

    // status codes
    localparam logic [3:0] ST_HLT = 4'd2;
    localparam logic [3:0] ST_ADR = 4'd3;
    localparam logic [3:0] ST_INS = 4'd4;

    localparam logic [3:0] REG_NONE = 4'hf;

    localparam logic [63:0] MINUS_EIGHT = 64'hffff_ffff_ffff_fff8;
    localparam logic [63:0] PLUS_EIGHT  = 64'd8;

    typedef struct packed {
        logic zf;
        logic sf;
        logic of;
    } flags_t;

endpackage

FILE: rtl/pes_alu.sv
// pes_alu: operand selection and 64-bit alu with overflow detect
// depends on pes_pkg
`timescale 1ns / 1ps

module pes_alu (
    input  logic [3:0]  icode,
    input  logic [3:0]  ifun,
    input  logic [63:0] val_a,
    input  logic [63:0] val_b,
    input  logic [63:0] val_c,
    output logic [63:0] result,
    output logic        ovf
);

    logic [63:0] op_a;
    logic [63:0] op_b;
    logic [3:0]  fn;

    always_comb begin
        op_a = '0;
        if (icode == pes_pkg::IC_RRMOVQ || icode == pes_pkg::IC_OPQ) begin
            op_a = val_a;
        end else if (icode == pes_pkg::IC_IRMOVQ || icode == pes_pkg::IC_RMMOVQ ||
                     icode == pes_pkg::IC_MRMOVQ) begin
            op_a = val_c;
        end else if (icode == pes_pkg::IC_CALL || icode == pes_pkg::IC_PUSHQ) begin
            op_a = pes_pkg::MINUS_EIGHT;
        end else if (icode == pes_pkg::IC_RET || icode == pes_pkg::IC_POPQ) begin
            op_a = pes_pkg::PLUS_EIGHT;
        end
    end

    always_comb begin
        op_b = '0;
        if (icode == pes_pkg::IC_RMMOVQ || icode == pes_pkg::IC_MRMOVQ ||
            icode == pes_pkg::IC_OPQ || icode == pes_pkg::IC_CALL ||
            icode == pes_pkg::IC_PUSHQ || icode == pes_pkg::IC_RET ||
            icode == pes_pkg::IC_POPQ) begin
            op_b = val_b;
        end
    end

    assign fn = (icode == pes_pkg::IC_OPQ) ? ifun : pes_pkg::FN_ADD;

    always_comb begin
        result = '1;
        ovf    = 1'b0;
        if (fn == pes_pkg::FN_ADD) begin
            result = op_a + op_b;
            ovf    = ~(op_a[63] ^ op_b[63]) & (result[63] ^ op_a[63]);
        end else if (fn == pes_pkg::FN_SUB) begin
            result = op_b - op_a;
            ovf    = (op_a[63] ^ op_b[63]) & (result[63] ^ op_b[63]);
        end else if (fn == pes_pkg::FN_AND) begin
            result = op_a & op_b;
        end else if (fn == pes_pkg::FN_XOR) begin
            result = op_a ^ op_b;
        end
    end

endmodule

FILE: rtl/pes_cond.sv
// pes_cond: condition evaluation for jump and conditional move
// depends on pes_pkg (flags_t, condition codes)
`timescale 1ns / 1ps

module pes_cond (
    input  logic [3:0]      icode,
    input  logic [3:0]      ifun,
    input  pes_pkg::flags_t flags,
    output logic            cnd
);

    logic lt;
    logic raw;

    assign lt = flags.sf ^ flags.of;

    always_comb begin
        unique case (ifun)
            pes_pkg::C_ALWAYS: raw = 1'b1;
            pes_pkg::C_LE:     raw = lt | flags.zf;
            pes_pkg::C_L:      raw = lt;
            pes_pkg::C_E:      raw = flags.zf;
            pes_pkg::C_NE:     raw = ~flags.zf;
            pes_pkg::C_GE:     raw = ~lt;
            pes_pkg::C_G:      raw = ~lt & ~flags.zf;
            default:           raw = 1'b0;
        endcase
    end

    assign cnd = raw & (icode == pes_pkg::IC_JXX || icode == pes_pkg::IC_RRMOVQ);

endmodule

FILE: rtl/pipelined_execute_stage_unit.sv
// pipelined_execute_stage_unit: top level of the execute stage
// depends on pes_pkg, pes_alu, pes_cond
`timescale 1ns / 1ps

// usage
// - input channel s_*: one execute-register bundle per beat, plus the statuses
//   now held in the memory and writeback stages
// - result channel m_*: the memory-register inputs and the bubble request
// - structure: input register -> operand select / alu / condition -> result
//   register; the condition flags are a register updated when an opq beat
//   passes to the result register and no halt, address or instruction
//   error is downstream, so beats see the flags left by all earlier beats
// - path: an accepted beat waits in the input register until the result
//   register is free or emptying, then moves there and raises m_valid
// - throughput: one beat per cycle while m_ready stays high
// - stall: while m_ready is low the result register holds; the input
//   register still takes one more beat, then s_ready drops until the
//   result is taken
// - reset (aresetn low, synchronous): both stages empty, flags cleared
module pipelined_execute_stage_unit (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_stat,
    input  logic [3:0]  s_icode,
    input  logic [3:0]  s_ifun,
    input  logic [63:0] s_val_a,
    input  logic [63:0] s_val_b,
    input  logic [63:0] s_val_c,
    input  logic [3:0]  s_dest_e,
    input  logic [3:0]  s_dest_m,
    input  logic [3:0]  s_mem_stage_status,
    input  logic [3:0]  s_wb_stage_status,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_out_stat,
    output logic [3:0]  m_out_icode,
    output logic        m_cond_true,
    output logic [63:0] m_alu_result,
    output logic [63:0] m_out_val_a,
    output logic [3:0]  m_out_dest_e,
    output logic [3:0]  m_out_dest_m,
    output logic        m_insert_bubble
);

    // input register
    logic        in_valid_reg;
    logic [3:0]  stat_reg, icode_reg, ifun_reg, dest_e_reg, dest_m_reg;
    logic [3:0]  mem_st_reg, wb_st_reg;
    logic [63:0] val_a_reg, val_b_reg, val_c_reg;

    // result register
    logic        out_valid_reg;
    logic [3:0]  o_stat_reg, o_icode_reg, o_dest_e_reg, o_dest_m_reg;
    logic        o_cond_reg, o_bubble_reg;
    logic [63:0] o_result_reg, o_val_a_reg;

    // condition flags
    pes_pkg::flags_t flags_reg, flags_next;

    logic        advance;
    logic [63:0] alu_out;
    logic        alu_ovf;
    logic        cnd;
    logic        blocked;
    logic [3:0]  dest_e_sel;

    // the input stage moves on when the result register is free or emptying
    assign advance = in_valid_reg & (~out_valid_reg | m_ready);
    assign s_ready = ~in_valid_reg | advance;

    pes_alu u_alu (
        .icode  (icode_reg),
        .ifun   (ifun_reg),
        .val_a  (val_a_reg),
        .val_b  (val_b_reg),
        .val_c  (val_c_reg),
        .result (alu_out),
        .ovf    (alu_ovf)
    );

    // flags only change on opq, so the condition always reads the register
    pes_cond u_cond (
        .icode (icode_reg),
        .ifun  (ifun_reg),
        .flags (flags_reg),
        .cnd   (cnd)
    );

    // halt, address error or bad instruction further down the pipe
    assign blocked = mem_st_reg == pes_pkg::ST_HLT || mem_st_reg == pes_pkg::ST_ADR ||
                     mem_st_reg == pes_pkg::ST_INS || wb_st_reg == pes_pkg::ST_HLT ||
                     wb_st_reg == pes_pkg::ST_ADR || wb_st_reg == pes_pkg::ST_INS;

    // a failed conditional move writes no register
    assign dest_e_sel = (icode_reg == pes_pkg::IC_RRMOVQ && !cnd) ? pes_pkg::REG_NONE
                                                                  : dest_e_reg;

    always_comb begin
        flags_next = flags_reg;
        if (advance && icode_reg == pes_pkg::IC_OPQ && !blocked) begin
            flags_next.zf = (alu_out == '0);
            flags_next.sf = alu_out[63];
            flags_next.of = alu_ovf;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end else begin
            flags_reg <= flags_next;
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload of the input register, loaded on accept
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            stat_reg   <= s_stat;
            icode_reg  <= s_icode;
            ifun_reg   <= s_ifun;
            val_a_reg  <= s_val_a;
            val_b_reg  <= s_val_b;
            val_c_reg  <= s_val_c;
            dest_e_reg <= s_dest_e;
            dest_m_reg <= s_dest_m;
            mem_st_reg <= s_mem_stage_status;
            wb_st_reg  <= s_wb_stage_status;
        end
    end

    // payload of the result register
    always_ff @(posedge aclk) begin
        if (advance) begin
            o_stat_reg   <= stat_reg;
            o_icode_reg  <= icode_reg;
            o_cond_reg   <= cnd;
            o_result_reg <= alu_out;
            o_val_a_reg  <= val_a_reg;
            o_dest_e_reg <= dest_e_sel;
            o_dest_m_reg <= dest_m_reg;
            o_bubble_reg <= blocked;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_out_stat      = o_stat_reg;
    assign m_out_icode     = o_icode_reg;
    assign m_cond_true     = o_cond_reg;
    assign m_alu_result    = o_result_reg;
    assign m_out_val_a     = o_val_a_reg;
    assign m_out_dest_e    = o_dest_e_reg;
    assign m_out_dest_m    = o_dest_m_reg;
    assign m_insert_bubble = o_bubble_reg;

endmodule

FILE: rtl/pes_checker.sv
// pes_checker: port-level assertions for pipelined_execute_stage_unit
// depends on pes_pkg; bound to the top level at the end of this file
`timescale 1ns / 1ps

module pes_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [3:0]  m_out_icode,
    input logic        m_cond_true,
    input logic [63:0] m_alu_result,
    input logic [3:0]  m_out_dest_e
);

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a stalled result stays
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_alu_result))
        else $error("stalled result changed");

    // an accepted beat reaches the result register if the sink is ready once the beat is in the input register
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) ##1 m_ready |=> m_valid)
        else $error("accepted beat did not reach the result register");

    // only jump and move can report a true condition
    a_cond_icode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_cond_true |->
            (m_out_icode == pes_pkg::IC_JXX || m_out_icode == pes_pkg::IC_RRMOVQ))
        else $error("condition true for non-branch instruction");

    // failed move has no destination
    a_cmov_dest: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_icode == pes_pkg::IC_RRMOVQ && !m_cond_true |->
            m_out_dest_e == pes_pkg::REG_NONE)
        else $error("failed cmov kept its destination");

endmodule

bind pipelined_execute_stage_unit pes_checker u_pes_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_out_icode  (m_out_icode),
    .m_cond_true  (m_cond_true),
    .m_alu_result (m_alu_result),
    .m_out_dest_e (m_out_dest_e)
);
